>>> rtl/core/ffpm_pkg.sv
// ----------------------------------------------------------------------------
// Fractal fold pixel mask - shared definitions
// Coordinate types, register map, reset values and fixed point helpers.
// ----------------------------------------------------------------------------
package ffpm_pkg;

	localparam int FOLD_STAGES_DEF = 2;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int MAX_DIM_DEF     = 1024;

	localparam int COORD_W    = 40;
	localparam int ANGLE_W    = 18;
	localparam int ZOOM_W     = 18;
	localparam int CTR_W      = 17;
	localparam int STEP_W     = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;
	localparam int WIDE_W     = 64;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [ANGLE_W-1:0] angle_t;
	typedef logic        [ZOOM_W-1:0]  zoom_t;
	typedef logic        [CTR_W-1:0]   ctr_t;
	typedef logic        [STEP_W-1:0]  step_t;
	typedef logic signed [WIDE_W-1:0]  wide_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} pt_t;

	typedef struct packed {
		angle_t cos_angle;
		angle_t sin_angle;
		zoom_t  zoom;
		ctr_t   center_x;
		ctr_t   center_y;
		step_t  step_x;
		step_t  step_y;
	} cfg_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COS_ANGLE,
		REG_SIN_ANGLE,
		REG_ZOOM,
		REG_CENTER_X,
		REG_CENTER_Y,
		REG_STEP_X,
		REG_STEP_Y
	} cfg_reg_e;

	localparam cfg_t CFG_RST = '{
		cos_angle: 18'sd65536,
		sin_angle: 18'sd0,
		zoom:      18'd98304,
		center_x:  17'd32768,
		center_y:  17'd32768,
		step_x:    17'd65536,
		step_y:    17'd65536
	};

	localparam wide_t COORD_MAX = (wide_t'(1) <<< (COORD_W - 1)) - wide_t'(1);
	localparam wide_t COORD_MIN = -COORD_MAX - wide_t'(1);

	function automatic coord_t sat_coord(input wide_t v);
		coord_t r;
		if (v > COORD_MAX)
			r = coord_t'(COORD_MAX[COORD_W-1:0]);
		else if (v < COORD_MIN)
			r = coord_t'(COORD_MIN[COORD_W-1:0]);
		else
			r = coord_t'(v[COORD_W-1:0]);
		return r;
	endfunction

	// round half up from 2*frac to frac fraction bits, then saturate
	function automatic coord_t round_frac(input wide_t v, input int frac);
		wide_t w;
		w = v + (wide_t'(1) <<< (frac - 1));
		return sat_coord(w >>> frac);
	endfunction

	// offset subtracted by fold stage number stage
	function automatic coord_t fold_offset(input int stage, input int frac);
		longint off;
		off = ((longint'(3) << frac) + 5) / 10;
		for (int i = 0; i < stage; i++)
			off = (off * 10 + 10) / 21;
		return coord_t'(off);
	endfunction

endpackage

>>> rtl/core/ffpm_front.sv
// ----------------------------------------------------------------------------
// Fractal fold pixel mask - coordinate front end
// Maps pixel position to centered coordinates, rotates by plus the angle
// and applies zoom over six pipeline stages.
// ----------------------------------------------------------------------------
module ffpm_front #(
	parameter int FRAC_BITS = ffpm_pkg::FRAC_BITS_DEF,
	parameter int MAX_DIM   = ffpm_pkg::MAX_DIM_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [$clog2(MAX_DIM)-1:0]     column,
	input  logic [$clog2(MAX_DIM)-1:0]     row,
	input  ffpm_pkg::cfg_t                 cfg,
	output logic                           out_valid,
	input  logic                           out_stall,
	output ffpm_pkg::pt_t                  out_pt,
	output logic [2*$clog2(MAX_DIM)-1:0]   out_tag
);
	import ffpm_pkg::*;

	localparam int POS_W = $clog2(MAX_DIM);
	localparam int TAG_W = 2 * POS_W;
	localparam int MAP_W = POS_W + STEP_W;
	localparam int X_W   = MAP_W + 1;
	localparam int ROT_W = X_W + ANGLE_W;
	localparam int ZP_W  = COORD_W + ZOOM_W + 1;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic adv1, adv2, adv3, adv4, adv5, adv6;

	logic [TAG_W-1:0] tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6;
	logic [MAP_W-1:0] px_s1, py_s1;
	logic signed [X_W-1:0] x_s2, y_s2;
	logic signed [ROT_W-1:0] xc_s3, ys_s3, xs_s3, yc_s3;
	coord_t nx_s4, ny_s4;
	logic signed [ZP_W-1:0] zx_s5, zy_s5;
	pt_t pt_s6;
	logic signed [ZP_W-1:0] zoom_ext;

	assign adv6 = !vld_s6 || !out_stall;
	assign adv5 = !vld_s5 || adv6;
	assign adv4 = !vld_s4 || adv5;
	assign adv3 = !vld_s3 || adv4;
	assign adv2 = !vld_s2 || adv3;
	assign adv1 = !vld_s1 || adv2;
	assign in_stall = !adv1;

	assign zoom_ext = ZP_W'($signed({1'b0, cfg.zoom}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= in_valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
			if (adv5) vld_s5 <= vld_s4;
			if (adv6) vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			tag_s1 <= {row, column};
			px_s1  <= MAP_W'(column) * MAP_W'(cfg.step_x);
			py_s1  <= MAP_W'(row) * MAP_W'(cfg.step_y);
		end
		if (adv2) begin
			tag_s2 <= tag_s1;
			x_s2   <= $signed({1'b0, px_s1}) - $signed(X_W'(cfg.center_x));
			y_s2   <= $signed({1'b0, py_s1}) - $signed(X_W'(cfg.center_y));
		end
		if (adv3) begin
			tag_s3 <= tag_s2;
			xc_s3  <= ROT_W'(x_s2) * ROT_W'(cfg.cos_angle);
			ys_s3  <= ROT_W'(y_s2) * ROT_W'(cfg.sin_angle);
			xs_s3  <= ROT_W'(x_s2) * ROT_W'(cfg.sin_angle);
			yc_s3  <= ROT_W'(y_s2) * ROT_W'(cfg.cos_angle);
		end
		if (adv4) begin
			tag_s4 <= tag_s3;
			nx_s4  <= round_frac(wide_t'(xc_s3) - wide_t'(ys_s3), FRAC_BITS);
			ny_s4  <= round_frac(wide_t'(xs_s3) + wide_t'(yc_s3), FRAC_BITS);
		end
		if (adv5) begin
			tag_s5 <= tag_s4;
			zx_s5  <= ZP_W'(nx_s4) * zoom_ext;
			zy_s5  <= ZP_W'(ny_s4) * zoom_ext;
		end
		if (adv6) begin
			tag_s6   <= tag_s5;
			pt_s6.x  <= round_frac(wide_t'(zx_s5), FRAC_BITS);
			pt_s6.y  <= round_frac(wide_t'(zy_s5), FRAC_BITS);
		end
	end

	assign out_valid = vld_s6;
	assign out_pt    = pt_s6;
	assign out_tag   = tag_s6;

endmodule

>>> rtl/core/ffpm_fold_cell.sv
// ----------------------------------------------------------------------------
// Fractal fold pixel mask - fold cell
// One fold: absolute value, subtract offset, rotate by minus the angle.
// Three pipeline stages; cells chain word to word.
// ----------------------------------------------------------------------------
module ffpm_fold_cell #(
	parameter int               FRAC_BITS = ffpm_pkg::FRAC_BITS_DEF,
	parameter int               MAX_DIM   = ffpm_pkg::MAX_DIM_DEF,
	parameter ffpm_pkg::coord_t OFFSET    = '0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  ffpm_pkg::pt_t                  in_pt,
	input  logic [2*$clog2(MAX_DIM)-1:0]   in_tag,
	input  ffpm_pkg::cfg_t                 cfg,
	output logic                           out_valid,
	input  logic                           out_stall,
	output ffpm_pkg::pt_t                  out_pt,
	output logic [2*$clog2(MAX_DIM)-1:0]   out_tag
);
	import ffpm_pkg::*;

	localparam int TAG_W = 2 * $clog2(MAX_DIM);
	localparam int AB_W  = COORD_W + 2;
	localparam int FP_W  = COORD_W + ANGLE_W;

	logic vld_s1, vld_s2, vld_s3;
	logic adv1, adv2, adv3;

	logic [TAG_W-1:0] tag_s1, tag_s2, tag_s3;
	logic signed [AB_W-1:0] abs_x, abs_y;
	pt_t fold_s1;
	logic signed [FP_W-1:0] xc_s2, ys_s2, yc_s2, xs_s2;
	pt_t pt_s3;

	assign adv3 = !vld_s3 || !out_stall;
	assign adv2 = !vld_s2 || adv3;
	assign adv1 = !vld_s1 || adv2;
	assign in_stall = !adv1;

	assign abs_x = in_pt.x[COORD_W-1] ? -AB_W'(in_pt.x) : AB_W'(in_pt.x);
	assign abs_y = in_pt.y[COORD_W-1] ? -AB_W'(in_pt.y) : AB_W'(in_pt.y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= in_valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			tag_s1    <= in_tag;
			fold_s1.x <= sat_coord(wide_t'(abs_x - AB_W'(OFFSET)));
			fold_s1.y <= sat_coord(wide_t'(abs_y - AB_W'(OFFSET)));
		end
		if (adv2) begin
			tag_s2 <= tag_s1;
			xc_s2  <= FP_W'(fold_s1.x) * FP_W'(cfg.cos_angle);
			ys_s2  <= FP_W'(fold_s1.y) * FP_W'(cfg.sin_angle);
			yc_s2  <= FP_W'(fold_s1.y) * FP_W'(cfg.cos_angle);
			xs_s2  <= FP_W'(fold_s1.x) * FP_W'(cfg.sin_angle);
		end
		if (adv3) begin
			tag_s3  <= tag_s2;
			pt_s3.x <= round_frac(wide_t'(xc_s2) + wide_t'(ys_s2), FRAC_BITS);
			pt_s3.y <= round_frac(wide_t'(yc_s2) - wide_t'(xs_s2), FRAC_BITS);
		end
	end

	assign out_valid = vld_s3;
	assign out_pt    = pt_s3;
	assign out_tag   = tag_s3;

endmodule

>>> rtl/core/ffpm_circle.sv
// ----------------------------------------------------------------------------
// Fractal fold pixel mask - circle test
// Marks a point lit when it lies inside the final circle; the last stage
// is the output register.
// ----------------------------------------------------------------------------
module ffpm_circle #(
	parameter int FOLD_STAGES = ffpm_pkg::FOLD_STAGES_DEF,
	parameter int FRAC_BITS   = ffpm_pkg::FRAC_BITS_DEF,
	parameter int MAX_DIM     = ffpm_pkg::MAX_DIM_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  ffpm_pkg::pt_t                  in_pt,
	input  logic [2*$clog2(MAX_DIM)-1:0]   in_tag,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           lit,
	output logic [2*$clog2(MAX_DIM)-1:0]   out_tag
);
	import ffpm_pkg::*;

	localparam int TAG_W = 2 * $clog2(MAX_DIM);
	localparam int AB_W  = COORD_W + 1;
	localparam int M_W   = FRAC_BITS - 2;
	localparam int SQ_W  = 2 * M_W;
	localparam int SUM_W = SQ_W + 1;
	localparam int LHS_W = SUM_W + 4 + 2 * FOLD_STAGES;
	localparam logic signed [AB_W-1:0] LIM   = AB_W'(1) <<< (FRAC_BITS - 3);
	localparam logic [LHS_W-1:0]       BOUND = LHS_W'(1) << (2 * FRAC_BITS);

	logic vld_s1, vld_s2, vld_s3;
	logic adv1, adv2, adv3;

	logic [TAG_W-1:0] tag_s1, tag_s2, tag_s3;
	logic signed [AB_W-1:0] abs_x, abs_y;
	logic near_s1, near_s2, lit_s3;
	logic [M_W-1:0] mx_s1, my_s1;
	logic [SQ_W-1:0] sqx_s2, sqy_s2;
	logic [SUM_W-1:0] sum;
	logic [LHS_W-1:0] lhs;

	assign adv3 = !vld_s3 || !out_stall;
	assign adv2 = !vld_s2 || adv3;
	assign adv1 = !vld_s1 || adv2;
	assign in_stall = !adv1;

	assign abs_x = in_pt.x[COORD_W-1] ? -AB_W'(in_pt.x) : AB_W'(in_pt.x);
	assign abs_y = in_pt.y[COORD_W-1] ? -AB_W'(in_pt.y) : AB_W'(in_pt.y);

	// 9 * (x^2 + y^2) * 4^stages
	assign sum = SUM_W'(sqx_s2) + SUM_W'(sqy_s2);
	assign lhs = ((LHS_W'(sum) << 3) + LHS_W'(sum)) << (2 * FOLD_STAGES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= in_valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			tag_s1  <= in_tag;
			near_s1 <= (abs_x <= LIM) && (abs_y <= LIM);
			mx_s1   <= abs_x[M_W-1:0];
			my_s1   <= abs_y[M_W-1:0];
		end
		if (adv2) begin
			tag_s2  <= tag_s1;
			near_s2 <= near_s1;
			sqx_s2  <= SQ_W'(mx_s1) * SQ_W'(mx_s1);
			sqy_s2  <= SQ_W'(my_s1) * SQ_W'(my_s1);
		end
		if (adv3) begin
			tag_s3 <= tag_s2;
			lit_s3 <= near_s2 && (lhs <= BOUND);
		end
	end

	assign out_valid = vld_s3;
	assign lit       = lit_s3;
	assign out_tag   = tag_s3;

endmodule

>>> rtl/core/fractal_fold_pixel_mask.sv
// ----------------------------------------------------------------------------
// Fractal fold pixel mask - top level
// Throughput: one pixel per cycle while mask_stall is low; front end, fold
// cells and circle test are a chain of registered stages from pixel word to
// mask word, each advancing into a free or freed slot.
// Reset clears all stage valid bits and loads register defaults; no sweep.
// ----------------------------------------------------------------------------
module fractal_fold_pixel_mask #(
	parameter int FOLD_STAGES = ffpm_pkg::FOLD_STAGES_DEF,
	parameter int FRAC_BITS   = ffpm_pkg::FRAC_BITS_DEF,
	parameter int MAX_DIM     = ffpm_pkg::MAX_DIM_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pix_valid,
	output logic                                pix_stall,
	input  logic [$clog2(MAX_DIM)-1:0]          column,
	input  logic [$clog2(MAX_DIM)-1:0]          row,
	output logic                                mask_valid,
	input  logic                                mask_stall,
	output logic                                lit,
	output logic [$clog2(MAX_DIM)-1:0]          out_column,
	output logic [$clog2(MAX_DIM)-1:0]          out_row,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ffpm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ffpm_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import ffpm_pkg::*;

	localparam int POS_W = $clog2(MAX_DIM);
	localparam int TAG_W = 2 * POS_W;

	cfg_t cfg_q;

	logic             chain_vld   [FOLD_STAGES+1];
	logic             chain_stall [FOLD_STAGES+1];
	pt_t              chain_pt    [FOLD_STAGES+1];
	logic [TAG_W-1:0] chain_tag   [FOLD_STAGES+1];
	logic [TAG_W-1:0] mask_tag;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_e'(cfg_index))
				REG_COS_ANGLE: cfg_q.cos_angle <= $signed(cfg_data);
				REG_SIN_ANGLE: cfg_q.sin_angle <= $signed(cfg_data);
				REG_ZOOM:      cfg_q.zoom      <= cfg_data;
				REG_CENTER_X:  cfg_q.center_x  <= cfg_data[CTR_W-1:0];
				REG_CENTER_Y:  cfg_q.center_y  <= cfg_data[CTR_W-1:0];
				REG_STEP_X:    cfg_q.step_x    <= cfg_data[STEP_W-1:0];
				REG_STEP_Y:    cfg_q.step_y    <= cfg_data[STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	ffpm_front #(
		.FRAC_BITS(FRAC_BITS),
		.MAX_DIM  (MAX_DIM)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix_valid),
		.in_stall (pix_stall),
		.column   (column),
		.row      (row),
		.cfg      (cfg_q),
		.out_valid(chain_vld[0]),
		.out_stall(chain_stall[0]),
		.out_pt   (chain_pt[0]),
		.out_tag  (chain_tag[0])
	);

	for (genvar k = 0; k < FOLD_STAGES; k++) begin : g_fold
		ffpm_fold_cell #(
			.FRAC_BITS(FRAC_BITS),
			.MAX_DIM  (MAX_DIM),
			.OFFSET   (fold_offset(k, FRAC_BITS))
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (chain_vld[k]),
			.in_stall (chain_stall[k]),
			.in_pt    (chain_pt[k]),
			.in_tag   (chain_tag[k]),
			.cfg      (cfg_q),
			.out_valid(chain_vld[k+1]),
			.out_stall(chain_stall[k+1]),
			.out_pt   (chain_pt[k+1]),
			.out_tag  (chain_tag[k+1])
		);
	end

	ffpm_circle #(
		.FOLD_STAGES(FOLD_STAGES),
		.FRAC_BITS  (FRAC_BITS),
		.MAX_DIM    (MAX_DIM)
	) u_circle (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chain_vld[FOLD_STAGES]),
		.in_stall (chain_stall[FOLD_STAGES]),
		.in_pt    (chain_pt[FOLD_STAGES]),
		.in_tag   (chain_tag[FOLD_STAGES]),
		.out_valid(mask_valid),
		.out_stall(mask_stall),
		.lit      (lit),
		.out_tag  (mask_tag)
	);

	assign out_column = mask_tag[POS_W-1:0];
	assign out_row    = mask_tag[TAG_W-1:POS_W];

	a_pix_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> chain_vld[0] && chain_stall[0])
		else $error("pixel stall without a held front word");

	for (genvar k = 0; k < FOLD_STAGES; k++) begin : g_chk
		a_cell_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
			chain_stall[k] |-> chain_vld[k+1] && chain_stall[k+1])
			else $error("fold cell stall without a held word downstream");
	end

	a_circle_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		chain_stall[FOLD_STAGES] |-> mask_valid && mask_stall)
		else $error("circle stall without a held mask word");

	a_stall_after_word: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pix_stall) |-> $past(pix_valid))
		else $error("pixel stall rose with no word taken before");

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// Fractal fold pixel mask - testbench
// Streams pixel words through the block and checks every mask word against
// a fixed point predictor of the fold and circle test. Frame registers are
// reprogrammed while the pipeline is empty, covering reset defaults, raw
// out-of-range values, the unused register index and realistic frames.
// Random phases vary source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb;
	import ffpm_pkg::*;

	localparam int PIX_W          = $clog2(MAX_DIM_DEF);
	localparam int FRAC           = FRAC_BITS_DEF;
	localparam int REG_COUNT      = 7;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = CFG_IDX_W'(REG_COUNT);
	localparam logic [PIX_W-1:0] PIX_LAST = PIX_W'(MAX_DIM_DEF - 1);
	localparam int DRAIN_CYCLES   = 9 + 3 * FOLD_STAGES_DEF + 8;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int BATCH_ITEMS    = 85;
	localparam longint COORD_HI   = (longint'(1) << (COORD_W - 1)) - 1;
	localparam longint COORD_LO   = -COORD_HI - 1;

	typedef struct {
		logic             lit;
		logic [PIX_W-1:0] col;
		logic [PIX_W-1:0] row;
	} mask_word_t;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  pix_valid  = 1'b0;
	logic                  pix_stall;
	logic [PIX_W-1:0]      column     = '0;
	logic [PIX_W-1:0]      row        = '0;
	logic                  mask_valid;
	logic                  mask_stall = 1'b0;
	logic                  lit;
	logic [PIX_W-1:0]      out_column;
	logic [PIX_W-1:0]      out_row;
	logic                  cfg_valid  = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;

	cfg_t                  frame_cfg  = CFG_RST;
	logic [CFG_DATA_W-1:0] frame_vals [REG_COUNT];
	mask_word_t            mask_queue [$];
	mask_word_t            exp_word;

	int idle_pct    = 0;
	int stall_pct   = 0;
	int cur_w       = MAX_DIM_DEF;
	int cur_h       = MAX_DIM_DEF;
	int pixels_sent = 0;
	int masks_seen  = 0;
	int lit_seen    = 0;
	int reg_writes  = 0;
	int mismatches  = 0;
	int idle_cycles = 0;

	fractal_fold_pixel_mask i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.column    (column),
		.row       (row),
		.mask_valid(mask_valid),
		.mask_stall(mask_stall),
		.lit       (lit),
		.out_column(out_column),
		.out_row   (out_row),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic longint coord_clamp(input longint v);
		if (v > COORD_HI)
			return COORD_HI;
		if (v < COORD_LO)
			return COORD_LO;
		return v;
	endfunction

	function automatic longint round_q16(input longint v);
		return coord_clamp((v + (longint'(1) << (FRAC - 1))) >>> FRAC);
	endfunction

	function automatic longint mag(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic logic fold_mask_lit(input logic [PIX_W-1:0] col_v,
			input logic [PIX_W-1:0] row_v);
		longint c, s, z, x, y, nx, ny, off, lim;
		c = {{(64 - ANGLE_W){frame_cfg.cos_angle[ANGLE_W-1]}}, frame_cfg.cos_angle};
		s = {{(64 - ANGLE_W){frame_cfg.sin_angle[ANGLE_W-1]}}, frame_cfg.sin_angle};
		z = longint'(frame_cfg.zoom);
		x = coord_clamp(longint'(col_v) * longint'(frame_cfg.step_x)
			- longint'(frame_cfg.center_x));
		y = coord_clamp(longint'(row_v) * longint'(frame_cfg.step_y)
			- longint'(frame_cfg.center_y));
		nx = round_q16(x * c - y * s);
		ny = round_q16(x * s + y * c);
		x = round_q16(nx * z);
		y = round_q16(ny * z);
		off = ((longint'(3) << FRAC) + 5) / 10;
		for (int i = 0; i < FOLD_STAGES_DEF; i++) begin
			x = coord_clamp(mag(x) - off);
			y = coord_clamp(mag(y) - off);
			nx = round_q16(x * c + y * s);
			ny = round_q16(y * c - x * s);
			x = nx;
			y = ny;
			off = (off * 10 + 10) / 21;
		end
		lim = longint'(1) << (FRAC - 3);
		if (mag(x) <= lim && mag(y) <= lim)
			return (((x * x + y * y) * 9) << (2 * FOLD_STAGES_DEF))
				<= (longint'(1) << (2 * FRAC));
		return 1'b0;
	endfunction

	// sink stall
	always @(posedge clk)
		mask_stall <= ($urandom_range(0, 99) < stall_pct);

	always @(posedge clk) begin
		if (arst_n && mask_valid && !mask_stall) begin
			masks_seen++;
			if (lit === 1'b1)
				lit_seen++;
			if (mask_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("tb: mask word with no pending pixel: lit %0b col %0d row %0d",
						lit, out_column, out_row);
			end else begin
				exp_word = mask_queue.pop_front();
				if (lit !== exp_word.lit || out_column !== exp_word.col
						|| out_row !== exp_word.row) begin
					mismatches++;
					if (mismatches <= 10)
						$display("tb: mask mismatch: expected lit %0b col %0d row %0d, %s %0b %0d %0d",
							exp_word.lit, exp_word.col, exp_word.row, "got",
							lit, out_column, out_row);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((pix_valid && !pix_stall) || (mask_valid && !mask_stall)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: watchdog expired with %0d mask words pending", mask_queue.size());
			$display("tb: errors");
			$finish;
		end
	end

	task automatic send_pixel(input logic [PIX_W-1:0] col_v, input logic [PIX_W-1:0] row_v);
		mask_word_t w;
		while ($urandom_range(0, 99) < idle_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		column    <= col_v;
		row       <= row_v;
		do
			@(posedge clk);
		while (pix_stall);
		w.lit = fold_mask_lit(col_v, row_v);
		w.col = col_v;
		w.row = row_v;
		mask_queue.push_back(w);
		pixels_sent++;
	endtask

	task automatic send_random_pixel();
		logic [PIX_W-1:0] c, r;
		if ($urandom_range(0, 99) < 85) begin
			c = PIX_W'($urandom_range(0, cur_w - 1));
			r = PIX_W'($urandom_range(0, cur_h - 1));
		end else begin
			c = PIX_W'($urandom_range(0, MAX_DIM_DEF - 1));
			r = PIX_W'($urandom_range(0, MAX_DIM_DEF - 1));
		end
		send_pixel(c, r);
	endtask

	task automatic drain_masks();
		pix_valid <= 1'b0;
		while (mask_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_COS_ANGLE: frame_cfg.cos_angle = data;
			REG_SIN_ANGLE: frame_cfg.sin_angle = data;
			REG_ZOOM:      frame_cfg.zoom      = data;
			REG_CENTER_X:  frame_cfg.center_x  = data[CTR_W-1:0];
			REG_CENTER_Y:  frame_cfg.center_y  = data[CTR_W-1:0];
			REG_STEP_X:    frame_cfg.step_x    = data[STEP_W-1:0];
			REG_STEP_Y:    frame_cfg.step_y    = data[STEP_W-1:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	// write all registers, then the unused index, which must change nothing
	task automatic write_frame();
		for (int i = 0; i < REG_COUNT; i++)
			write_reg(CFG_IDX_W'(i), frame_vals[i]);
		write_reg(REG_NONE, CFG_DATA_W'($urandom()));
		cfg_valid <= 1'b0;
	endtask

	function automatic int dim_step(input int dim);
		return (65536 + (dim - 1) / 2) / (dim - 1);
	endfunction

	task automatic program_frame(input bit raw);
		real a;
		if (raw) begin
			for (int i = 0; i < REG_COUNT; i++)
				frame_vals[i] = CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1));
			cur_w = MAX_DIM_DEF;
			cur_h = MAX_DIM_DEF;
		end else begin
			a = 10.0 * ($urandom_range(0, 1000) / 1000.0);
			cur_w = ($urandom_range(0, 99) < 70) ? $urandom_range(2, 64)
				: $urandom_range(2, MAX_DIM_DEF);
			cur_h = ($urandom_range(0, 99) < 70) ? $urandom_range(2, 64)
				: $urandom_range(2, MAX_DIM_DEF);
			frame_vals[REG_COS_ANGLE] = CFG_DATA_W'($rtoi($floor($cos(a) * 65536.0 + 0.5)));
			frame_vals[REG_SIN_ANGLE] = CFG_DATA_W'($rtoi($floor($sin(a) * 65536.0 + 0.5)));
			frame_vals[REG_ZOOM]      = CFG_DATA_W'($rtoi($floor(($sin(a) * 0.5 + 1.5)
				* 65536.0 + 0.5)));
			frame_vals[REG_CENTER_X]  = ($urandom_range(0, 99) < 70) ? CFG_DATA_W'(32768)
				: CFG_DATA_W'($urandom_range(0, 65536));
			frame_vals[REG_CENTER_Y]  = ($urandom_range(0, 99) < 70) ? CFG_DATA_W'(32768)
				: CFG_DATA_W'($urandom_range(0, 65536));
			frame_vals[REG_STEP_X]    = CFG_DATA_W'(dim_step(cur_w));
			frame_vals[REG_STEP_Y]    = CFG_DATA_W'(dim_step(cur_h));
		end
		write_frame();
	endtask

	task automatic test_reset_defaults();
		send_pixel('0, '0);
		send_pixel(PIX_LAST, PIX_LAST);
		send_pixel('0, PIX_LAST);
		send_pixel(PIX_LAST, '0);
		send_pixel(PIX_W'(1), '0);
		drain_masks();
	endtask

	task automatic test_register_extremes();
		frame_vals[REG_COS_ANGLE] = 18'h20000;
		frame_vals[REG_SIN_ANGLE] = 18'h1FFFF;
		frame_vals[REG_ZOOM]      = 18'h3FFFF;
		frame_vals[REG_CENTER_X]  = 18'h3FFFF;
		frame_vals[REG_CENTER_Y]  = 18'h00000;
		frame_vals[REG_STEP_X]    = 18'h3FFFF;
		frame_vals[REG_STEP_Y]    = 18'h20000;
		write_frame();
		send_pixel('0, '0);
		send_pixel(PIX_LAST, PIX_LAST);
		send_pixel('0, PIX_LAST);
		send_pixel(PIX_LAST, '0);
		drain_masks();
		frame_vals[REG_COS_ANGLE] = CFG_DATA_W'(-65536);
		frame_vals[REG_SIN_ANGLE] = CFG_DATA_W'(65536);
		frame_vals[REG_ZOOM]      = CFG_DATA_W'(65536);
		frame_vals[REG_CENTER_X]  = '0;
		frame_vals[REG_CENTER_Y]  = CFG_DATA_W'(65536);
		frame_vals[REG_STEP_X]    = CFG_DATA_W'(65536);
		frame_vals[REG_STEP_Y]    = '0;
		write_frame();
		send_pixel('0, '0);
		send_pixel(PIX_LAST, PIX_LAST);
		send_pixel(PIX_W'(1), PIX_W'(1));
		send_pixel(PIX_LAST, '0);
		drain_masks();
	endtask

	// small square frame, zero angle: sweep part of one row across the folds
	task automatic test_lit_region();
		cur_w = 24;
		cur_h = 24;
		frame_vals[REG_COS_ANGLE] = CFG_DATA_W'(65536);
		frame_vals[REG_SIN_ANGLE] = '0;
		frame_vals[REG_ZOOM]      = CFG_DATA_W'(98304);
		frame_vals[REG_CENTER_X]  = CFG_DATA_W'(32768);
		frame_vals[REG_CENTER_Y]  = CFG_DATA_W'(32768);
		frame_vals[REG_STEP_X]    = CFG_DATA_W'(dim_step(cur_w));
		frame_vals[REG_STEP_Y]    = CFG_DATA_W'(dim_step(cur_h));
		write_frame();
		for (int i = 0; i < 12; i += 2)
			send_pixel(PIX_W'(i), PIX_W'(12));
		send_pixel(PIX_W'(3), PIX_W'(3));
		send_pixel(PIX_W'(20), PIX_W'(4));
		drain_masks();
	endtask

	task automatic test_random_phases();
		int idle_set [4];
		int stall_set [4];
		idle_set  = '{0, 60, 0, 25};
		stall_set = '{0, 0, 60, 25};
		for (int p = 0; p < 4; p++) begin
			idle_pct  = idle_set[p];
			stall_pct = stall_set[p];
			for (int k = 0; k < 2; k++) begin
				// hold the source until the pipeline is empty
				drain_masks();
				program_frame(($urandom_range(0, 99) < 20) || (p == 3 && k == 1));
				repeat (BATCH_ITEMS) send_random_pixel();
			end
		end
		drain_masks();
		idle_pct  = 0;
		stall_pct = 0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_register_extremes();
		test_lit_region();
		test_random_phases();
		drain_masks();
		$display("tb: %0d pixels sent, %0d mask words checked, %0d lit", pixels_sent,
			masks_seen, lit_seen);
		$display("tb: %0d register writes over default, extreme, raw and frame settings",
			reg_writes);
		if (mismatches == 0 && mask_queue.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

>>> files.f
rtl/core/ffpm_pkg.sv
rtl/core/ffpm_front.sv
rtl/core/ffpm_fold_cell.sv
rtl/core/ffpm_circle.sv
rtl/core/fractal_fold_pixel_mask.sv
verif/tb.sv
